// File: sv/icr_pkg.sv
package icr_pkg;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED       = 2'd3;

    localparam int unsigned RESET_MODULUS    = 65521;
    localparam int unsigned RESET_MULTIPLIER = 1;
    localparam int unsigned RESET_INCREMENT  = 3;
    localparam int unsigned RESET_SEED       = 2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_X,
        OP_DIV_EU,
        OP_DIV_INC,
        OP_DIV_STEP,
        OP_EU_INIT,
        OP_EU_UPD,
        OP_INV,
        OP_MUL_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic rc_zero;
        logic mul_last;
    } t_status;

endpackage

// File: sv/inversive_congruential_rng_unit.sv
// Inversive congruential generator: each item whose step request is set replaces the
// residue x with (multiplier * inverse(x) + increment) mod modulus and delivers the new
// residue as one result item; an item with the flag clear is accepted and gives nothing.
// A residue without an inverse contributes a zero product. The modular inverse is
// found by the extended Euclidean algorithm on a shared shift-subtract divider that produces
// one quotient bit per cycle. An item reduces the residue, starts the Euclid loop, runs
// its steps (each a division and an update) until the remainder is zero, closes the loop,
// performs the bit-serial multiply-mod over the multiplier bits, reduces the increment
// and then delivers the result. The length of the Euclid sequence sets the spread in how
// long an item takes; reducing a residue or an increment takes longer the further its
// leading bit lies above that of the modulus. Writing the seed register also loads the
// residue.
// The result register lets the finished item wait while the next item is accepted; the
// next item then cannot finish until the waiting result is taken.
module inversive_congruential_rng_unit #(
    parameter int VALUE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_step_request,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [VALUE_BITS-1:0]             o_random_value,
    input  logic                              i_cfg_we,
    input  logic [icr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]             i_cfg_data
);
    import icr_pkg::*;

    t_cmd    cmd;
    t_status status;

    icr_controller u_controller (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_step_request (i_step_request),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    icr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_value     (o_random_value)
    );

endmodule

// File: sv/icr_datapath.sv
module icr_datapath #(
    parameter int VALUE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [icr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [VALUE_BITS-1:0]             i_cfg_data,
    input  icr_pkg::t_cmd                     i_cmd,
    output icr_pkg::t_status                  o_status,
    output logic [VALUE_BITS-1:0]             o_value
);
    import icr_pkg::*;

    localparam int TW = VALUE_BITS + 2;
    localparam int CW = $clog2(VALUE_BITS);

    function automatic logic [CW-1:0] msb_pos(input logic [VALUE_BITS-1:0] v);
        logic [CW-1:0] p;
        p = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (v[i]) begin
                p = CW'(i);
            end
        end
        return p;
    endfunction

    logic [VALUE_BITS-1:0] r_modulus;
    logic [VALUE_BITS-1:0] r_multiplier;
    logic [VALUE_BITS-1:0] r_increment;
    logic [VALUE_BITS-1:0] r_residue;

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_ds;
    logic [CW-1:0]         r_cnt;
    logic signed [TW-1:0]  r_acc;
    logic [VALUE_BITS-1:0] r_rp;
    logic [VALUE_BITS-1:0] r_rc;
    logic signed [TW-1:0]  r_tp;
    logic signed [TW-1:0]  r_tc;
    logic [VALUE_BITS-1:0] r_inv;
    logic [VALUE_BITS-1:0] r_hacc;
    logic [CW-1:0]         r_hidx;
    logic [VALUE_BITS-1:0] r_out;

    logic [VALUE_BITS-1:0] m_eff;
    logic signed [TW-1:0]  m_s;
    logic [VALUE_BITS:0]   m_w;
    logic [VALUE_BITS-1:0] div_num;
    logic [VALUE_BITS-1:0] div_den;
    logic [CW-1:0]         pa;
    logic [CW-1:0]         pb;
    logic [CW-1:0]         shift;
    logic [VALUE_BITS-1:0] ds_init;
    logic                  ge;
    logic [VALUE_BITS-1:0] rem_step;
    logic signed [TW-1:0]  acc_step;
    logic signed [TW-1:0]  tp_adj;
    logic signed [TW-1:0]  inv_full;
    logic [VALUE_BITS-1:0] inv_val;
    logic [VALUE_BITS:0]   s1;
    logic [VALUE_BITS:0]   s1r;
    logic [VALUE_BITS:0]   s2;
    logic [VALUE_BITS:0]   s2r;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS:0]   sumr;

    assign m_eff = (r_modulus < VALUE_BITS'(2)) ? VALUE_BITS'(1) : r_modulus;
    assign m_s   = signed'({2'b00, m_eff});
    assign m_w   = {1'b0, m_eff};

    always_comb begin
        case (i_cmd.op)
            OP_DIV_X: begin
                div_num = r_residue;
                div_den = m_eff;
            end
            OP_DIV_EU: begin
                div_num = r_rp;
                div_den = r_rc;
            end
            default: begin
                div_num = r_increment;
                div_den = m_eff;
            end
        endcase
    end

    assign pa      = msb_pos(div_num);
    assign pb      = msb_pos(div_den);
    assign shift   = (pa > pb) ? pa - pb : '0;
    assign ds_init = div_den << shift;

    assign ge       = (r_rem >= r_ds);
    assign rem_step = ge ? r_rem - r_ds : r_rem;
    assign acc_step = r_acc + r_acc + (ge ? r_tc : TW'(0));

    assign tp_adj   = r_tp[TW-1] ? r_tp + m_s : r_tp;
    assign inv_full = (tp_adj >= m_s) ? tp_adj - m_s : tp_adj;
    assign inv_val  = (r_rp == VALUE_BITS'(1)) ? inv_full[VALUE_BITS-1:0] : '0;

    assign s1  = {r_hacc, 1'b0};
    assign s1r = (s1 >= m_w) ? s1 - m_w : s1;
    assign s2  = s1r + (r_multiplier[r_hidx] ? {1'b0, r_inv} : '0);
    assign s2r = (s2 >= m_w) ? s2 - m_w : s2;

    assign sum  = {1'b0, r_hacc} + {1'b0, r_rem};
    assign sumr = (sum >= m_w) ? sum - m_w : sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= VALUE_BITS'(RESET_MODULUS);
            r_multiplier <= VALUE_BITS'(RESET_MULTIPLIER);
            r_increment  <= VALUE_BITS'(RESET_INCREMENT);
            r_residue    <= VALUE_BITS'(RESET_SEED);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODULUS:    r_modulus    <= i_cfg_data;
                    REG_MULTIPLIER: r_multiplier <= i_cfg_data;
                    REG_INCREMENT:  r_increment  <= i_cfg_data;
                    REG_SEED:       r_residue    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_FINISH) begin
                r_residue <= sumr[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_DIV_X, OP_DIV_EU, OP_DIV_INC: begin
                r_rem <= div_num;
                r_ds  <= ds_init;
                r_cnt <= shift;
                r_acc <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_step;
                r_ds  <= r_ds >> 1;
                r_cnt <= r_cnt - CW'(1);
                r_acc <= acc_step;
            end
            OP_EU_INIT: begin
                r_rp <= m_eff;
                r_rc <= r_rem;
                r_tp <= '0;
                r_tc <= TW'(1);
            end
            OP_EU_UPD: begin
                r_rp <= r_rc;
                r_rc <= r_rem;
                r_tp <= r_tc;
                r_tc <= r_tp - r_acc;
            end
            OP_INV: begin
                r_inv  <= inv_val;
                r_hacc <= '0;
                r_hidx <= CW'(VALUE_BITS - 1);
            end
            OP_MUL_STEP: begin
                r_hacc <= s2r[VALUE_BITS-1:0];
                r_hidx <= r_hidx - CW'(1);
            end
            OP_FINISH: begin
                r_out <= sumr[VALUE_BITS-1:0];
            end
            default: ;
        endcase
    end

    assign o_status.div_last = (r_cnt == '0);
    assign o_status.rc_zero  = (r_rc == '0);
    assign o_status.mul_last = (r_hidx == '0);
    assign o_value           = r_out;

endmodule

// File: sv/icr_controller.sv
module icr_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_step_request,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  icr_pkg::t_status i_status,
    output icr_pkg::t_cmd    o_cmd
);
    import icr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_X_RUN   = 10'b0000000010,
        S_EU_INIT = 10'b0000000100,
        S_EU_TEST = 10'b0000001000,
        S_EU_RUN  = 10'b0000010000,
        S_EU_UPD  = 10'b0000100000,
        S_MUL     = 10'b0001000000,
        S_INC_SET = 10'b0010000000,
        S_INC_RUN = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_write;

    assign can_write = !r_out_valid || !i_stall;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_step_request) begin
                    o_cmd.op = OP_DIV_X;
                    n_state  = S_X_RUN;
                end
            end
            S_X_RUN: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_EU_INIT;
                end
            end
            S_EU_INIT: begin
                o_cmd.op = OP_EU_INIT;
                n_state  = S_EU_TEST;
            end
            S_EU_TEST: begin
                if (i_status.rc_zero) begin
                    o_cmd.op = OP_INV;
                    n_state  = S_MUL;
                end else begin
                    o_cmd.op = OP_DIV_EU;
                    n_state  = S_EU_RUN;
                end
            end
            S_EU_RUN: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_EU_UPD;
                end
            end
            S_EU_UPD: begin
                o_cmd.op = OP_EU_UPD;
                n_state  = S_EU_TEST;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_status.mul_last) begin
                    n_state = S_INC_SET;
                end
            end
            S_INC_SET: begin
                o_cmd.op = OP_DIV_INC;
                n_state  = S_INC_RUN;
            end
            S_INC_RUN: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (can_write) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.op == OP_FINISH) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule
